### sv/mi4_pkg.sv
// mi4_pkg: shared constants, types and fixed-point helpers of the 4x4 LU inverter
// used by mi4_mul, mi4_div, the channel interfaces and matrix4_inverse_lu
`default_nettype none
package mi4_pkg;

  localparam int DIM    = 4;
  localparam int IW     = 2;
  localparam int QW     = 48;
  localparam int VW     = 32;
  localparam int AW     = 5;
  localparam int BW     = 4;

  localparam logic [QW-1:0] Q_ONE     = 48'h0001_0000_0000;
  localparam logic [QW-1:0] Q_MAX     = 48'h7fff_ffff_ffff;
  localparam logic [QW-1:0] Q_MIN_MAG = 48'h8000_0000_0000;
  localparam logic [QW-1:0] Q_LSB     = 48'h0000_0000_0001;
  localparam logic [IW-1:0] LAST_IDX  = IW'(DIM - 1);

  // request into the shared multiply or divide unit
  typedef struct packed {
    logic          go;
    logic [QW-1:0] a_mag;
    logic [QW-1:0] b_mag;
    logic          neg;
  } mi4_op_t;

  typedef enum logic [5:0] {
    ST_IDLE,
    ST_SC_RD, ST_SC_CAP, ST_SC_CHK, ST_SC_DIV,
    ST_DC_COL, ST_DC_SRD, ST_DC_SCAP, ST_DC_KCHK, ST_DC_KA, ST_DC_KB, ST_DC_KW,
    ST_DC_DUM, ST_DC_DUMW, ST_DC_NEXTI,
    ST_DC_SW, ST_DC_SW1, ST_DC_SW2, ST_DC_SW3, ST_DC_SWS, ST_DC_SWS1,
    ST_DC_PVT, ST_DC_PV1, ST_DC_DRD, ST_DC_DDV, ST_DC_DDW, ST_DC_NEXTJ,
    ST_SV_INIT, ST_SF_PIV, ST_SF_1, ST_SF_2, ST_SF_K, ST_SF_KM, ST_SF_KW,
    ST_SB_RD, ST_SB_1, ST_SB_K, ST_SB_KM, ST_SB_KW, ST_SB_DV, ST_SB_DW,
    ST_EM_RD, ST_EM_CAP, ST_EM_WAIT
  } state_t;

  // magnitude of a Q16.32 value, -2^47 maps to 2^47
  function automatic logic [QW-1:0] q_mag(input logic [QW-1:0] x);
    q_mag = x[QW-1] ? (~x + Q_LSB) : x;
  endfunction

  // apply sign and clamp to the 48-bit range
  function automatic logic [QW-1:0] q_cap(input logic [63:0] m, input logic neg);
    logic [63:0] c;
    c = m;
    if (neg) begin
      if (c > {16'd0, Q_MIN_MAG}) c = {16'd0, Q_MIN_MAG};
      q_cap = ~c[QW-1:0] + Q_LSB;
    end else begin
      if (c > {16'd0, Q_MAX}) c = {16'd0, Q_MAX};
      q_cap = c[QW-1:0];
    end
  endfunction

  // saturating a - b
  function automatic logic [QW-1:0] q_sub(input logic [QW-1:0] a, input logic [QW-1:0] b);
    logic [QW:0] d;
    d = {a[QW-1], a} - {b[QW-1], b};
    if (d[QW] != d[QW-1]) q_sub = d[QW] ? Q_MIN_MAG : Q_MAX;
    else q_sub = d[QW-1:0];
  endfunction

  function automatic logic [AW-1:0] a_addr(input logic [IW-1:0] i, input logic [IW-1:0] k);
    a_addr = {1'b0, i, k};
  endfunction

  function automatic logic [AW-1:0] s_addr(input logic [IW-1:0] i);
    s_addr = {3'b100, i};
  endfunction

endpackage
`default_nettype wire

### sv/mi4_in_if.sv
// mi4_in_if: element load channel of the inverter
// depends on mi4_pkg for field widths
`default_nettype none
interface mi4_in_if;
  logic                         valid;
  logic                         ready;
  logic [mi4_pkg::IW-1:0]       row;
  logic [mi4_pkg::IW-1:0]       col;
  logic signed [mi4_pkg::VW-1:0] value;
  logic                         go;

  modport source (output valid, row, col, value, go, input ready);
  modport sink (input valid, row, col, value, go, output ready);
endinterface
`default_nettype wire

### sv/mi4_out_if.sv
// mi4_out_if: result channel of the inverter
// depends on mi4_pkg for field widths
`default_nettype none
interface mi4_out_if;
  logic                          valid;
  logic                          ready;
  logic [mi4_pkg::IW-1:0]        out_row;
  logic [mi4_pkg::IW-1:0]        out_col;
  logic signed [mi4_pkg::VW-1:0] out_value;
  logic                          singular;
  logic                          last;

  modport source (output valid, out_row, out_col, out_value, singular, last, input ready);
  modport sink (input valid, out_row, out_col, out_value, singular, last, output ready);
endinterface
`default_nettype wire

### sv/mi4_mul.sv
// mi4_mul: Q16.32 multiply, four 32x32 partial products on one multiplier
// depends on mi4_pkg (mi4_op_t, q_cap)
`default_nettype none
module mi4_mul (
  input  wire logic                   clk,
  input  wire logic                   rst_n,
  input  wire mi4_pkg::mi4_op_t       op,
  output logic                        done,
  output logic [mi4_pkg::QW-1:0]      p
);

  logic [mi4_pkg::QW-1:0] a_r, b_r;
  logic                   neg_r;
  logic [63:0]            acc_r;
  logic [63:0]            prod_r;
  logic [2:0]             cnt_r;
  logic                   busy_r;
  logic                   done_r;
  logic [31:0]            x, y;
  logic [1:0]             prev;
  logic [63:0]            addend;

  // operand pair for this step
  always_comb begin
    x = 32'd0;
    y = 32'd0;
    case (cnt_r[1:0])
      2'd0: begin x = a_r[31:0];            y = b_r[31:0]; end
      2'd1: begin x = {16'd0, a_r[47:32]};  y = b_r[31:0]; end
      2'd2: begin x = a_r[31:0];            y = {16'd0, b_r[47:32]}; end
      default: begin x = {16'd0, a_r[47:32]}; y = {16'd0, b_r[47:32]}; end
    endcase
  end

  // alignment of the previous partial product
  assign prev = 2'(cnt_r - 3'd1);
  always_comb begin
    case (prev)
      2'd0:    addend = {32'd0, prod_r[63:32]};
      2'd3:    addend = {prod_r[31:0], 32'd0};
      default: addend = prod_r;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      cnt_r  <= 3'd0;
    end else begin
      done_r <= 1'b0;
      if (op.go) begin
        a_r    <= op.a_mag;
        b_r    <= op.b_mag;
        neg_r  <= op.neg;
        acc_r  <= 64'd0;
        cnt_r  <= 3'd0;
        busy_r <= 1'b1;
      end else if (busy_r) begin
        if (cnt_r != 3'd4) prod_r <= x * y;
        if (cnt_r != 3'd0) acc_r <= acc_r + addend;
        if (cnt_r == 3'd4) begin
          busy_r <= 1'b0;
          done_r <= 1'b1;
        end
        cnt_r <= cnt_r + 3'd1;
      end
    end
  end

  assign done = done_r;
  assign p    = mi4_pkg::q_cap(acc_r, neg_r);

endmodule
`default_nettype wire

### sv/mi4_div.sv
// mi4_div: Q16.32 divide (a*2^32)/b, restoring, one quotient bit per cycle
// depends on mi4_pkg (mi4_op_t, q_cap)
`default_nettype none
module mi4_div (
  input  wire logic                   clk,
  input  wire logic                   rst_n,
  input  wire mi4_pkg::mi4_op_t       op,
  output logic                        done,
  output logic [mi4_pkg::QW-1:0]      q
);

  localparam int STEPS = mi4_pkg::QW + 32;

  logic [mi4_pkg::QW-1:0] sh_r, b_r, r_r, q_r;
  logic                   neg_r, over_r, busy_r, done_r;
  logic [6:0]             cnt_r;
  logic [mi4_pkg::QW:0]   rs, rd;
  logic                   ge;

  // one restoring step
  assign rs = {r_r, sh_r[mi4_pkg::QW-1]};
  assign ge = rs >= {1'b0, b_r};
  assign rd = ge ? (rs - {1'b0, b_r}) : rs;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      cnt_r  <= 7'd0;
    end else begin
      done_r <= 1'b0;
      if (op.go) begin
        sh_r   <= op.a_mag;
        b_r    <= (op.b_mag == '0) ? mi4_pkg::Q_LSB : op.b_mag;
        neg_r  <= op.neg;
        r_r    <= '0;
        q_r    <= '0;
        over_r <= 1'b0;
        cnt_r  <= 7'd0;
        busy_r <= 1'b1;
      end else if (busy_r) begin
        sh_r <= {sh_r[mi4_pkg::QW-2:0], 1'b0};
        r_r  <= rd[mi4_pkg::QW-1:0];
        q_r  <= {q_r[mi4_pkg::QW-2:0], ge};
        // quotient bits above bit 47 mean overflow
        if (ge && cnt_r < 7'(STEPS - mi4_pkg::QW)) over_r <= 1'b1;
        if (cnt_r == 7'(STEPS - 1)) begin
          busy_r <= 1'b0;
          done_r <= 1'b1;
        end
        cnt_r <= cnt_r + 7'd1;
      end
    end
  end

  assign done = done_r;
  assign q = mi4_pkg::q_cap({16'd0, over_r ? mi4_pkg::Q_MIN_MAG : q_r}, neg_r);

endmodule
`default_nettype wire

### sv/matrix4_inverse_lu.sv
// matrix4_inverse_lu: 4x4 inverse by Crout LU with implicit scaling and pivoting
// depends on mi4_pkg, mi4_in_if, mi4_out_if, mi4_mul, mi4_div
//
//  channel  | dir | payload                                       | transaction
//  in_ch    | in  | row, col, value (Q16.16), go                   | one element load
//  out_ch   | out | out_row, out_col, out_value, singular, last    | one inverse element
//
// a load is written straight into memory; an item with go starts a run paced
// by the bit-serial divider (26 divides) and the multiplier, all working on the
// 20-entry work memory.
// results leave one at a time, each held until the sink takes it.
// rst_n returns the sequencer to idle; memory contents are not cleared.
// no load is taken while a run or its results are in progress.
`default_nettype none
module matrix4_inverse_lu (
  input  wire logic clk,
  input  wire logic rst_n,
  mi4_in_if.sink    in_ch,
  mi4_out_if.source out_ch
);

  localparam int QW = mi4_pkg::QW;
  localparam int IW = mi4_pkg::IW;

  // work memory: matrix entries then row scales
  logic [QW-1:0] mem_a [0:mi4_pkg::DIM*mi4_pkg::DIM+mi4_pkg::DIM-1];
  logic          a_we;
  logic [mi4_pkg::AW-1:0] a_wa, a_ra;
  logic [QW-1:0] a_wd, a_rd_r;
  // inverse memory, column c of it is the solve vector
  logic [QW-1:0] mem_b [0:mi4_pkg::DIM*mi4_pkg::DIM-1];
  logic          b_we;
  logic [mi4_pkg::BW-1:0] b_wa, b_ra;
  logic [QW-1:0] b_wd, b_rd_r;

  mi4_pkg::state_t state_r, state_nxt;
  logic [IW-1:0] ci_r, ci_nxt, cj_r, cj_nxt, cc_r, cc_nxt;
  logic [IW:0]   ck_r, ck_nxt;
  logic [mi4_pkg::BW-1:0] n_r, n_nxt;
  logic [QW-1:0] acc_r, acc_nxt, big_r, big_nxt, bigd_r, bigd_nxt;
  logic [QW-1:0] tmp_r, tmp_nxt, pv_r, pv_nxt;
  logic [IW-1:0] imax_r, imax_nxt, ip_r, ip_nxt;
  logic [IW-1:0] piv_r [0:mi4_pkg::DIM-1];
  logic          piv_we;

  logic                    o_valid_r, o_valid_nxt, o_sing_r, o_sing_nxt, o_last_r, o_last_nxt;
  logic [IW-1:0]           o_row_r, o_row_nxt, o_col_r, o_col_nxt;
  logic [mi4_pkg::VW-1:0]  o_val_r, o_val_nxt;

  mi4_pkg::mi4_op_t mul_op, div_op;
  logic             mul_done, div_done;
  logic [QW-1:0]    mul_p, div_q;
  logic [IW-1:0]    klim;
  logic [QW-1:0]    a_mag_rd;

  mi4_mul u_mul (.clk(clk), .rst_n(rst_n), .op(mul_op), .done(mul_done), .p(mul_p));
  mi4_div u_div (.clk(clk), .rst_n(rst_n), .op(div_op), .done(div_done), .q(div_q));

  // memories
  always_ff @(posedge clk) begin
    if (a_we) mem_a[a_wa] <= a_wd;
    a_rd_r <= mem_a[a_ra];
  end

  always_ff @(posedge clk) begin
    if (b_we) mem_b[b_wa] <= b_wd;
    b_rd_r <= mem_b[b_ra];
  end

  always_ff @(posedge clk) begin
    if (piv_we) piv_r[cj_r] <= imax_r;
  end

  assign klim     = (ci_r < cj_r) ? ci_r : cj_r;
  assign a_mag_rd = mi4_pkg::q_mag(a_rd_r);

  // sequencer
  always_comb begin
    state_nxt = state_r;
    ci_nxt = ci_r; cj_nxt = cj_r; ck_nxt = ck_r; cc_nxt = cc_r; n_nxt = n_r;
    acc_nxt = acc_r; big_nxt = big_r; bigd_nxt = bigd_r;
    tmp_nxt = tmp_r; pv_nxt = pv_r; imax_nxt = imax_r; ip_nxt = ip_r;
    o_valid_nxt = o_valid_r; o_sing_nxt = o_sing_r; o_last_nxt = o_last_r;
    o_row_nxt = o_row_r; o_col_nxt = o_col_r; o_val_nxt = o_val_r;
    a_we = 1'b0; a_wa = '0; a_wd = '0; a_ra = '0;
    b_we = 1'b0; b_wa = '0; b_wd = '0; b_ra = '0;
    piv_we = 1'b0;
    mul_op = '0;
    div_op = '0;

    unique case (state_r)
      mi4_pkg::ST_IDLE: begin
        if (in_ch.valid) begin
          a_we = 1'b1;
          a_wa = mi4_pkg::a_addr(in_ch.row, in_ch.col);
          a_wd = {in_ch.value, 16'd0};
          if (in_ch.go) begin
            ci_nxt = '0; cj_nxt = '0; big_nxt = '0;
            state_nxt = mi4_pkg::ST_SC_RD;
          end
        end
      end

      // row scale: largest magnitude per row, then its reciprocal; an all-zero row ends the run as singular
      mi4_pkg::ST_SC_RD: begin
        a_ra = mi4_pkg::a_addr(ci_r, cj_r);
        state_nxt = mi4_pkg::ST_SC_CAP;
      end
      mi4_pkg::ST_SC_CAP: begin
        if (a_mag_rd > big_r) big_nxt = a_mag_rd;
        if (cj_r == mi4_pkg::LAST_IDX) state_nxt = mi4_pkg::ST_SC_CHK;
        else begin
          cj_nxt = cj_r + 1'b1;
          state_nxt = mi4_pkg::ST_SC_RD;
        end
      end
      mi4_pkg::ST_SC_CHK: begin
        if (big_r == '0) begin
          o_valid_nxt = 1'b1; o_sing_nxt = 1'b1; o_last_nxt = 1'b1;
          o_row_nxt = '0; o_col_nxt = '0; o_val_nxt = '0;
          state_nxt = mi4_pkg::ST_EM_WAIT;
        end else begin
          div_op = '{go: 1'b1, a_mag: mi4_pkg::Q_ONE, b_mag: big_r, neg: 1'b0};
          state_nxt = mi4_pkg::ST_SC_DIV;
        end
      end
      mi4_pkg::ST_SC_DIV: begin
        if (div_done) begin
          a_we = 1'b1; a_wa = mi4_pkg::s_addr(ci_r); a_wd = div_q;
          big_nxt = '0; cj_nxt = '0;
          if (ci_r == mi4_pkg::LAST_IDX) state_nxt = mi4_pkg::ST_DC_COL;
          else begin
            ci_nxt = ci_r + 1'b1;
            state_nxt = mi4_pkg::ST_SC_RD;
          end
        end
      end

      // decomposition, column cj
      mi4_pkg::ST_DC_COL: begin
        bigd_nxt = '0; imax_nxt = cj_r; ci_nxt = '0;
        state_nxt = mi4_pkg::ST_DC_SRD;
      end
      mi4_pkg::ST_DC_SRD: begin
        a_ra = mi4_pkg::a_addr(ci_r, cj_r);
        state_nxt = mi4_pkg::ST_DC_SCAP;
      end
      mi4_pkg::ST_DC_SCAP: begin
        acc_nxt = a_rd_r; ck_nxt = '0;
        state_nxt = mi4_pkg::ST_DC_KCHK;
      end
      mi4_pkg::ST_DC_KCHK: begin
        if (ck_r < {1'b0, klim}) begin
          a_ra = mi4_pkg::a_addr(ci_r, ck_r[IW-1:0]);
          state_nxt = mi4_pkg::ST_DC_KA;
        end else begin
          a_we = 1'b1; a_wa = mi4_pkg::a_addr(ci_r, cj_r); a_wd = acc_r;
          if (ci_r >= cj_r) begin
            a_ra = mi4_pkg::s_addr(ci_r);
            state_nxt = mi4_pkg::ST_DC_DUM;
          end else state_nxt = mi4_pkg::ST_DC_NEXTI;
        end
      end
      mi4_pkg::ST_DC_KA: begin
        tmp_nxt = a_rd_r;
        a_ra = mi4_pkg::a_addr(ck_r[IW-1:0], cj_r);
        state_nxt = mi4_pkg::ST_DC_KB;
      end
      mi4_pkg::ST_DC_KB: begin
        mul_op = '{go: 1'b1, a_mag: mi4_pkg::q_mag(tmp_r), b_mag: a_mag_rd,
                   neg: tmp_r[QW-1] ^ a_rd_r[QW-1]};
        state_nxt = mi4_pkg::ST_DC_KW;
      end
      mi4_pkg::ST_DC_KW: begin
        if (mul_done) begin
          acc_nxt = mi4_pkg::q_sub(acc_r, mul_p);
          ck_nxt = ck_r + 1'b1;
          state_nxt = mi4_pkg::ST_DC_KCHK;
        end
      end
      mi4_pkg::ST_DC_DUM: begin
        mul_op = '{go: 1'b1, a_mag: a_mag_rd, b_mag: mi4_pkg::q_mag(acc_r),
                   neg: a_rd_r[QW-1]};
        state_nxt = mi4_pkg::ST_DC_DUMW;
      end
      mi4_pkg::ST_DC_DUMW: begin
        if (mul_done) begin
          if ($signed(mul_p) >= $signed(bigd_r)) begin
            bigd_nxt = mul_p; imax_nxt = ci_r;
          end
          state_nxt = mi4_pkg::ST_DC_NEXTI;
        end
      end
      mi4_pkg::ST_DC_NEXTI: begin
        if (ci_r == mi4_pkg::LAST_IDX) begin
          ck_nxt = '0;
          state_nxt = mi4_pkg::ST_DC_SW;
        end else begin
          ci_nxt = ci_r + 1'b1;
          state_nxt = mi4_pkg::ST_DC_SRD;
        end
      end

      // row interchange
      mi4_pkg::ST_DC_SW: begin
        if (imax_r == cj_r) state_nxt = mi4_pkg::ST_DC_PVT;
        else begin
          a_ra = mi4_pkg::a_addr(imax_r, ck_r[IW-1:0]);
          state_nxt = mi4_pkg::ST_DC_SW1;
        end
      end
      mi4_pkg::ST_DC_SW1: begin
        tmp_nxt = a_rd_r;
        a_ra = mi4_pkg::a_addr(cj_r, ck_r[IW-1:0]);
        state_nxt = mi4_pkg::ST_DC_SW2;
      end
      mi4_pkg::ST_DC_SW2: begin
        a_we = 1'b1; a_wa = mi4_pkg::a_addr(imax_r, ck_r[IW-1:0]); a_wd = a_rd_r;
        state_nxt = mi4_pkg::ST_DC_SW3;
      end
      mi4_pkg::ST_DC_SW3: begin
        a_we = 1'b1; a_wa = mi4_pkg::a_addr(cj_r, ck_r[IW-1:0]); a_wd = tmp_r;
        if (ck_r[IW-1:0] == mi4_pkg::LAST_IDX) state_nxt = mi4_pkg::ST_DC_SWS;
        else begin
          ck_nxt = ck_r + 1'b1;
          state_nxt = mi4_pkg::ST_DC_SW;
        end
      end
      mi4_pkg::ST_DC_SWS: begin
        a_ra = mi4_pkg::s_addr(cj_r);
        state_nxt = mi4_pkg::ST_DC_SWS1;
      end
      mi4_pkg::ST_DC_SWS1: begin
        a_we = 1'b1; a_wa = mi4_pkg::s_addr(imax_r); a_wd = a_rd_r;
        state_nxt = mi4_pkg::ST_DC_PVT;
      end

      // pivot record, zero pivot fix, scale the column below
      mi4_pkg::ST_DC_PVT: begin
        piv_we = 1'b1;
        a_ra = mi4_pkg::a_addr(cj_r, cj_r);
        state_nxt = mi4_pkg::ST_DC_PV1;
      end
      mi4_pkg::ST_DC_PV1: begin
        if (a_rd_r == '0) begin
          a_we = 1'b1; a_wa = mi4_pkg::a_addr(cj_r, cj_r); a_wd = mi4_pkg::Q_LSB;
          pv_nxt = mi4_pkg::Q_LSB;
        end else pv_nxt = a_rd_r;
        if (cj_r == mi4_pkg::LAST_IDX) state_nxt = mi4_pkg::ST_DC_NEXTJ;
        else begin
          ci_nxt = cj_r + 1'b1;
          state_nxt = mi4_pkg::ST_DC_DRD;
        end
      end
      mi4_pkg::ST_DC_DRD: begin
        a_ra = mi4_pkg::a_addr(ci_r, cj_r);
        state_nxt = mi4_pkg::ST_DC_DDV;
      end
      mi4_pkg::ST_DC_DDV: begin
        div_op = '{go: 1'b1, a_mag: a_mag_rd, b_mag: mi4_pkg::q_mag(pv_r),
                   neg: a_rd_r[QW-1] ^ pv_r[QW-1]};
        state_nxt = mi4_pkg::ST_DC_DDW;
      end
      mi4_pkg::ST_DC_DDW: begin
        if (div_done) begin
          a_we = 1'b1; a_wa = mi4_pkg::a_addr(ci_r, cj_r); a_wd = div_q;
          if (ci_r == mi4_pkg::LAST_IDX) state_nxt = mi4_pkg::ST_DC_NEXTJ;
          else begin
            ci_nxt = ci_r + 1'b1;
            state_nxt = mi4_pkg::ST_DC_DRD;
          end
        end
      end
      mi4_pkg::ST_DC_NEXTJ: begin
        if (cj_r == mi4_pkg::LAST_IDX) begin
          cc_nxt = '0; ck_nxt = '0;
          state_nxt = mi4_pkg::ST_SV_INIT;
        end else begin
          cj_nxt = cj_r + 1'b1;
          state_nxt = mi4_pkg::ST_DC_COL;
        end
      end

      // unit column cc
      mi4_pkg::ST_SV_INIT: begin
        b_we = 1'b1; b_wa = {ck_r[IW-1:0], cc_r};
        b_wd = (ck_r[IW-1:0] == cc_r) ? mi4_pkg::Q_ONE : '0;
        if (ck_r[IW-1:0] == mi4_pkg::LAST_IDX) begin
          ci_nxt = '0;
          state_nxt = mi4_pkg::ST_SF_PIV;
        end else ck_nxt = ck_r + 1'b1;
      end

      // forward substitution with the row interchanges
      mi4_pkg::ST_SF_PIV: begin
        ip_nxt = piv_r[ci_r];
        b_ra = {piv_r[ci_r], cc_r};
        state_nxt = mi4_pkg::ST_SF_1;
      end
      mi4_pkg::ST_SF_1: begin
        acc_nxt = b_rd_r;
        b_ra = {ci_r, cc_r};
        state_nxt = mi4_pkg::ST_SF_2;
      end
      mi4_pkg::ST_SF_2: begin
        b_we = 1'b1; b_wa = {ip_r, cc_r}; b_wd = b_rd_r;
        ck_nxt = '0;
        state_nxt = mi4_pkg::ST_SF_K;
      end
      mi4_pkg::ST_SF_K: begin
        if (ck_r < {1'b0, ci_r}) begin
          a_ra = mi4_pkg::a_addr(ci_r, ck_r[IW-1:0]);
          b_ra = {ck_r[IW-1:0], cc_r};
          state_nxt = mi4_pkg::ST_SF_KM;
        end else begin
          b_we = 1'b1; b_wa = {ci_r, cc_r}; b_wd = acc_r;
          if (ci_r == mi4_pkg::LAST_IDX) state_nxt = mi4_pkg::ST_SB_RD;
          else begin
            ci_nxt = ci_r + 1'b1;
            state_nxt = mi4_pkg::ST_SF_PIV;
          end
        end
      end
      mi4_pkg::ST_SF_KM: begin
        mul_op = '{go: 1'b1, a_mag: a_mag_rd, b_mag: mi4_pkg::q_mag(b_rd_r),
                   neg: a_rd_r[QW-1] ^ b_rd_r[QW-1]};
        state_nxt = mi4_pkg::ST_SF_KW;
      end
      mi4_pkg::ST_SF_KW: begin
        if (mul_done) begin
          acc_nxt = mi4_pkg::q_sub(acc_r, mul_p);
          ck_nxt = ck_r + 1'b1;
          state_nxt = mi4_pkg::ST_SF_K;
        end
      end

      // back substitution, ci counts down from the last row
      mi4_pkg::ST_SB_RD: begin
        b_ra = {ci_r, cc_r};
        state_nxt = mi4_pkg::ST_SB_1;
      end
      mi4_pkg::ST_SB_1: begin
        acc_nxt = b_rd_r;
        ck_nxt = {1'b0, ci_r} + 1'b1;
        state_nxt = mi4_pkg::ST_SB_K;
      end
      mi4_pkg::ST_SB_K: begin
        if (ck_r < (IW+1)'(mi4_pkg::DIM)) begin
          a_ra = mi4_pkg::a_addr(ci_r, ck_r[IW-1:0]);
          b_ra = {ck_r[IW-1:0], cc_r};
          state_nxt = mi4_pkg::ST_SB_KM;
        end else begin
          a_ra = mi4_pkg::a_addr(ci_r, ci_r);
          state_nxt = mi4_pkg::ST_SB_DV;
        end
      end
      mi4_pkg::ST_SB_KM: begin
        mul_op = '{go: 1'b1, a_mag: a_mag_rd, b_mag: mi4_pkg::q_mag(b_rd_r),
                   neg: a_rd_r[QW-1] ^ b_rd_r[QW-1]};
        state_nxt = mi4_pkg::ST_SB_KW;
      end
      mi4_pkg::ST_SB_KW: begin
        if (mul_done) begin
          acc_nxt = mi4_pkg::q_sub(acc_r, mul_p);
          ck_nxt = ck_r + 1'b1;
          state_nxt = mi4_pkg::ST_SB_K;
        end
      end
      mi4_pkg::ST_SB_DV: begin
        div_op = '{go: 1'b1, a_mag: mi4_pkg::q_mag(acc_r), b_mag: a_mag_rd,
                   neg: acc_r[QW-1] ^ a_rd_r[QW-1]};
        state_nxt = mi4_pkg::ST_SB_DW;
      end
      mi4_pkg::ST_SB_DW: begin
        if (div_done) begin
          b_we = 1'b1; b_wa = {ci_r, cc_r}; b_wd = div_q;
          if (ci_r == '0) begin
            if (cc_r == mi4_pkg::LAST_IDX) begin
              n_nxt = '0;
              state_nxt = mi4_pkg::ST_EM_RD;
            end else begin
              cc_nxt = cc_r + 1'b1; ck_nxt = '0;
              state_nxt = mi4_pkg::ST_SV_INIT;
            end
          end else begin
            ci_nxt = ci_r - 1'b1;
            state_nxt = mi4_pkg::ST_SB_RD;
          end
        end
      end

      // results in row-major order
      mi4_pkg::ST_EM_RD: begin
        b_ra = n_r;
        state_nxt = mi4_pkg::ST_EM_CAP;
      end
      mi4_pkg::ST_EM_CAP: begin
        o_valid_nxt = 1'b1; o_sing_nxt = 1'b0;
        o_last_nxt = (n_r == mi4_pkg::BW'(mi4_pkg::DIM*mi4_pkg::DIM-1));
        o_row_nxt = n_r[mi4_pkg::BW-1:IW]; o_col_nxt = n_r[IW-1:0];
        o_val_nxt = b_rd_r[QW-1:16];
        state_nxt = mi4_pkg::ST_EM_WAIT;
      end
      mi4_pkg::ST_EM_WAIT: begin
        if (out_ch.ready) begin
          o_valid_nxt = 1'b0;
          if (o_last_r) state_nxt = mi4_pkg::ST_IDLE;
          else begin
            n_nxt = n_r + 1'b1;
            state_nxt = mi4_pkg::ST_EM_RD;
          end
        end
      end
      default: state_nxt = mi4_pkg::ST_IDLE;
    endcase
  end

  // control registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r   <= mi4_pkg::ST_IDLE;
      o_valid_r <= 1'b0;
    end else begin
      state_r   <= state_nxt;
      o_valid_r <= o_valid_nxt;
    end
  end

  // datapath registers
  always_ff @(posedge clk) begin
    ci_r <= ci_nxt; cj_r <= cj_nxt; ck_r <= ck_nxt; cc_r <= cc_nxt; n_r <= n_nxt;
    acc_r <= acc_nxt; big_r <= big_nxt; bigd_r <= bigd_nxt;
    tmp_r <= tmp_nxt; pv_r <= pv_nxt; imax_r <= imax_nxt; ip_r <= ip_nxt;
    o_sing_r <= o_sing_nxt; o_last_r <= o_last_nxt;
    o_row_r <= o_row_nxt; o_col_r <= o_col_nxt; o_val_r <= o_val_nxt;
  end

  assign in_ch.ready      = (state_r == mi4_pkg::ST_IDLE);
  assign out_ch.valid     = o_valid_r;
  assign out_ch.out_row   = o_row_r;
  assign out_ch.out_col   = o_col_r;
  assign out_ch.out_value = o_val_r;
  assign out_ch.singular  = o_sing_r;
  assign out_ch.last      = o_last_r;

endmodule
`default_nettype wire

### verif/tb_matrix4_inverse_lu.sv
// tb_matrix4_inverse_lu: self-checking bench for the 4x4 lu matrix inverter
// depends on mi4_pkg, mi4_in_if, mi4_out_if and matrix4_inverse_lu
`timescale 1ns / 100ps
module tb_matrix4_inverse_lu;

  localparam int DIM = mi4_pkg::DIM;
  localparam int IW  = mi4_pkg::IW;
  localparam int VW  = mi4_pkg::VW;

  typedef struct {
    logic [IW-1:0]        row;
    logic [IW-1:0]        col;
    logic signed [VW-1:0] value;
    logic                 singular;
    logic                 last;
  } inv_elem_t;

  logic clk = 1'b0;
  logic rst_n = 1'b0;
  mi4_in_if  in_ch ();
  mi4_out_if out_ch ();

  matrix4_inverse_lu dut (.clk(clk), .rst_n(rst_n), .in_ch(in_ch), .out_ch(out_ch));

  always #1 clk = ~clk;

  // mirror of the block state, q16.32 in 64-bit containers
  longint    lu_mem [DIM*DIM];
  longint    scale_mem [DIM];
  int        pivot_mem [DIM];
  longint    inv_mem [DIM*DIM];
  inv_elem_t inverse_q [$];

  int  errors = 0;
  int  n_loads = 0;
  int  n_runs = 0;
  int  n_singular = 0;
  int  n_results = 0;
  bit  idle_on = 1'b1;
  int  rx_hold = 0;

  localparam longint SAT_MAX = 64'sh0000_7fff_ffff_ffff;
  localparam longint SAT_MIN = -64'sh0000_8000_0000_0000;
  localparam longint ONE_Q   = 64'sh0000_0001_0000_0000;

  function automatic longint sat48(longint x);
    if (x > SAT_MAX) return SAT_MAX;
    if (x < SAT_MIN) return SAT_MIN;
    return x;
  endfunction

  function automatic longint unsigned mag64(longint x);
    return x < 0 ? 64'd0 - longint'(x) : x;
  endfunction

  function automatic longint cap_signed(longint unsigned m, bit neg);
    if (neg) begin
      if (m > 64'h8000_0000_0000) m = 64'h8000_0000_0000;
      return longint'(64'd0 - m);
    end
    if (m > 64'h7fff_ffff_ffff) m = 64'h7fff_ffff_ffff;
    return longint'(m);
  endfunction

  function automatic longint fx_mul(longint a, longint b);
    longint unsigned ua, ub, a1, a0, b1, b0, m;
    ua = mag64(a);
    ub = mag64(b);
    a1 = ua >> 32;
    a0 = ua & 64'hffff_ffff;
    b1 = ub >> 32;
    b0 = ub & 64'hffff_ffff;
    m = ((a1 * b1) << 32) + a1 * b0 + a0 * b1 + ((a0 * b0) >> 32);
    return cap_signed(m, (a < 0) != (b < 0));
  endfunction

  // restoring division of a*2^32 by b, overflow saturates
  function automatic longint fx_div(longint a, longint b);
    longint unsigned ua, ub, r, q, bt;
    bit over;
    ua = mag64(a);
    ub = mag64(b);
    r = 0;
    q = 0;
    over = 1'b0;
    if (ub == 0) ub = 1;
    for (int k = 79; k >= 0; k--) begin
      bt = (k >= 32) ? ((ua >> (k - 32)) & 64'd1) : 64'd0;
      r = (r << 1) | bt;
      if (r >= ub) begin
        r = r - ub;
        if (k >= 48) over = 1'b1;
        else q = q | (64'd1 << k);
      end
    end
    if (over) q = 64'h8000_0000_0000;
    return cap_signed(q, (a < 0) != (b < 0));
  endfunction

  // crout factorization in place with implicit scaling and pivoting
  function automatic void factor_lu();
    longint s, big, dum, t;
    int imax;
    for (int j = 0; j < DIM; j++) begin
      big = 0;
      for (int i = 0; i < j; i++) begin
        s = lu_mem[i*DIM+j];
        for (int k = 0; k < i; k++) s = sat48(s - fx_mul(lu_mem[i*DIM+k], lu_mem[k*DIM+j]));
        lu_mem[i*DIM+j] = s;
      end
      imax = j;
      for (int i = j; i < DIM; i++) begin
        s = lu_mem[i*DIM+j];
        for (int k = 0; k < j; k++) s = sat48(s - fx_mul(lu_mem[i*DIM+k], lu_mem[k*DIM+j]));
        lu_mem[i*DIM+j] = s;
        dum = fx_mul(scale_mem[i], longint'(mag64(s)));
        if (dum >= big) begin
          big = dum;
          imax = i;
        end
      end
      if (imax != j) begin
        for (int k = 0; k < DIM; k++) begin
          t = lu_mem[imax*DIM+k];
          lu_mem[imax*DIM+k] = lu_mem[j*DIM+k];
          lu_mem[j*DIM+k] = t;
        end
        scale_mem[imax] = scale_mem[j];
      end
      pivot_mem[j] = imax;
      // zero pivot becomes one lsb
      if (lu_mem[j*DIM+j] == 0) lu_mem[j*DIM+j] = 1;
      if (j != DIM - 1)
        for (int i = j + 1; i < DIM; i++) lu_mem[i*DIM+j] = fx_div(lu_mem[i*DIM+j], lu_mem[j*DIM+j]);
    end
  endfunction

  function automatic void solve_unit_col(int c);
    longint b [DIM];
    longint s;
    int ip;
    for (int i = 0; i < DIM; i++) b[i] = 0;
    b[c] = ONE_Q;
    for (int i = 0; i < DIM; i++) begin
      ip = pivot_mem[i];
      s = b[ip];
      b[ip] = b[i];
      for (int j = 0; j < i; j++) s = sat48(s - fx_mul(lu_mem[i*DIM+j], b[j]));
      b[i] = s;
    end
    for (int i = DIM - 1; i >= 0; i--) begin
      s = b[i];
      for (int j = i + 1; j < DIM; j++) s = sat48(s - fx_mul(lu_mem[i*DIM+j], b[j]));
      b[i] = fx_div(s, lu_mem[i*DIM+i]);
    end
    for (int i = 0; i < DIM; i++) inv_mem[i*DIM+c] = b[i];
  endfunction

  // store one element and, on go, queue the inverse elements it yields
  function automatic void predict_inverse(logic [IW-1:0] r, logic [IW-1:0] c,
                                          logic signed [VW-1:0] v, logic go);
    longint unsigned big, m;
    logic [63:0] raw;
    inv_elem_t e;
    lu_mem[r*DIM+c] = longint'(v) * 65536;
    n_loads++;
    if (!go) return;
    n_runs++;
    for (int i = 0; i < DIM; i++) begin
      big = 0;
      for (int j = 0; j < DIM; j++) begin
        m = mag64(lu_mem[i*DIM+j]);
        if (m > big) big = m;
      end
      // an all-zero row gives a single flagged result
      if (big == 0) begin
        e = '{row: '0, col: '0, value: '0, singular: 1'b1, last: 1'b1};
        inverse_q.push_back(e);
        n_singular++;
        return;
      end
      scale_mem[i] = fx_div(ONE_Q, longint'(big));
    end
    factor_lu();
    for (int j = 0; j < DIM; j++) solve_unit_col(j);
    for (int i = 0; i < DIM; i++)
      for (int j = 0; j < DIM; j++) begin
        raw = inv_mem[i*DIM+j];
        e.row = IW'(i);
        e.col = IW'(j);
        e.value = raw[47:16];
        e.singular = 1'b0;
        e.last = (i == DIM - 1 && j == DIM - 1);
        inverse_q.push_back(e);
      end
  endfunction

  // one load transaction, sometimes a random gap afterwards while idling is on
  task automatic send_elem(int r, int c, logic signed [VW-1:0] v, bit go);
    in_ch.valid <= 1'b1;
    in_ch.row   <= IW'(r);
    in_ch.col   <= IW'(c);
    in_ch.value <= v;
    in_ch.go    <= go;
    do @(posedge clk); while (!in_ch.ready);
    predict_inverse(IW'(r), IW'(c), v, go);
    if (idle_on && $urandom_range(0, 3) == 0) begin
      in_ch.valid <= 1'b0;
      repeat ($urandom_range(1, 18)) @(posedge clk);
    end
  endtask

  function automatic logic signed [VW-1:0] rand_value();
    case ($urandom_range(0, 4))
      0: return $urandom;
      1: return $signed($urandom_range(0, 32'h0008_0000)) - 32'sh0004_0000;
      2: return $signed($urandom_range(0, 16)) * 32'sh0001_0000 - 32'sh0008_0000;
      3: begin
        case ($urandom_range(0, 4))
          0: return 32'sh7fff_ffff;
          1: return -32'sh8000_0000;
          2: return 32'sh0000_0001;
          3: return -32'sh0000_0001;
          default: return 32'sh0000_0000;
        endcase
      end
      default: return $signed($urandom_range(0, 32'h0400_0000)) - 32'sh0200_0000;
    endcase
  endfunction

  task automatic load_matrix();
    for (int r = 0; r < DIM; r++)
      for (int c = 0; c < DIM; c++)
        send_elem(r, c, rand_value(), (r == DIM - 1 && c == DIM - 1));
  endtask

  task automatic wait_drained();
    in_ch.valid <= 1'b0;
    while (inverse_q.size() != 0) @(posedge clk);
    repeat (50) @(posedge clk);
  endtask

  // identity, zero row, go without reload, extreme entries
  task automatic test_directed();
    for (int r = 0; r < DIM; r++)
      for (int c = 0; c < DIM; c++)
        send_elem(r, c, (r == c) ? 32'sh0001_0000 : 32'sh0, (r == DIM - 1 && c == DIM - 1));
    for (int c = 0; c < DIM; c++) send_elem(2, c, 32'sh0, c == DIM - 1);
    send_elem(1, 1, 32'sh7fff_ffff, 1'b0);
    send_elem(2, 0, -32'sh8000_0000, 1'b1);
    send_elem(0, 0, 32'sh0000_0001, 1'b1);
    send_elem(3, 3, -32'sh0000_0001, 1'b1);
  endtask

  // sender holds off until every pending result is out
  task automatic test_pause();
    wait_drained();
    send_elem(0, 3, rand_value(), 1'b1);
    wait_drained();
  endtask

  // mostly complete loads, some proportional rows for zero pivots, partial reloads, zero rows and noise
  task automatic test_random(int n_items);
    int sent, k, r0, v;
    sent = 0;
    while (sent < n_items) begin
      k = $urandom_range(0, 9);
      if (k < 4) begin
        load_matrix();
        sent += DIM * DIM;
      end else if (k < 6) begin
        v = $urandom_range(1, 3);
        for (int r = 0; r < DIM; r++)
          for (int c = 0; c < DIM; c++)
            send_elem(r, c, (r == v) ? 32'sh0001_0000 * (c + 1) : 32'sh0001_0000 * (c + 1) * (r + 2),
                      (r == DIM - 1 && c == DIM - 1));
        sent += DIM * DIM;
      end else if (k < 8) begin
        r0 = $urandom_range(1, 6);
        for (int i = 0; i < r0; i++)
          send_elem($urandom_range(0, 3), $urandom_range(0, 3), rand_value(), i == r0 - 1);
        sent += r0;
      end else if (k == 8) begin
        r0 = $urandom_range(0, 3);
        for (int c = 0; c < DIM; c++) send_elem(r0, c, 32'sh0, c == DIM - 1);
        sent += DIM;
      end else begin
        send_elem($urandom_range(0, 3), $urandom_range(0, 3), rand_value(), 1'b0);
        sent++;
      end
    end
  endtask

  // result sink with random stall bursts
  always @(posedge clk) begin
    if (rx_hold > 0) begin
      rx_hold <= rx_hold - 1;
      out_ch.ready <= 1'b0;
    end else if (idle_on && $urandom_range(0, 7) == 0) begin
      rx_hold <= $urandom_range(0, 17);
      out_ch.ready <= 1'b0;
    end else begin
      out_ch.ready <= 1'b1;
    end
  end

  // compare each result transaction with the oldest prediction
  always @(posedge clk) begin
    inv_elem_t e;
    if (rst_n && out_ch.valid && out_ch.ready) begin
      n_results++;
      if (inverse_q.size() == 0) begin
        $error("unexpected result transaction row %0d col %0d", out_ch.out_row, out_ch.out_col);
        errors++;
      end else begin
        e = inverse_q.pop_front();
        if (out_ch.out_row !== e.row) begin
          $error("out_row expected %0d actual %0d", e.row, out_ch.out_row);
          errors++;
        end
        if (out_ch.out_col !== e.col) begin
          $error("out_col expected %0d actual %0d", e.col, out_ch.out_col);
          errors++;
        end
        if (out_ch.out_value !== e.value) begin
          $error("out_value expected %0h actual %0h", e.value, out_ch.out_value);
          errors++;
        end
        if (out_ch.singular !== e.singular) begin
          $error("singular expected %0b actual %0b", e.singular, out_ch.singular);
          errors++;
        end
        if (out_ch.last !== e.last) begin
          $error("last expected %0b actual %0b", e.last, out_ch.last);
          errors++;
        end
      end
    end
  end

  initial begin
    #4000000;
    $display("matrix4_inverse_lu: mismatch");
    $finish;
  end

  initial begin
    in_ch.valid <= 1'b0;
    in_ch.row <= '0;
    in_ch.col <= '0;
    in_ch.value <= '0;
    in_ch.go <= 1'b0;
    repeat (8) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);
    test_directed();
    test_pause();
    test_random(100);
    // last stretch without any idling
    idle_on = 1'b0;
    test_random(25);
    in_ch.valid <= 1'b0;
    while (inverse_q.size() != 0) @(posedge clk);
    repeat (3000) @(posedge clk);
    if (inverse_q.size() != 0) begin
      $error("%0d predicted results never arrived", inverse_q.size());
      errors++;
    end
    $display("covered %0d loads, %0d inversions (%0d singular), %0d results checked",
             n_loads, n_runs, n_singular, n_results);
    if (errors == 0) begin
      $display("matrix4_inverse_lu: match");
    end else begin
      $display("matrix4_inverse_lu: mismatch");
    end
    $finish;
  end
endmodule
